// File: src/hatt_pkg.sv
// Shared types and constants for the Hilbert axes-to-transpose block.
// Holds field widths, configuration register indexes and the config struct.
// No dependencies.
package hatt_pkg;

    localparam int FIELD_AXES = 4;   // coordinate fields carried on the stream
    localparam int FIELD_W    = 32;  // width of one coordinate / index field
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int BPA_W      = 6;   // bits_per_axis register width
    localparam int AXES_W     = 3;   // num_axes register width

    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_AXIS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES      = 1'b1;

    // Effective (clamped) configuration handed to every cell
    typedef struct packed {
        logic [BPA_W-1:0]  eff_bits;
        logic [AXES_W-1:0] eff_axes;
    } hatt_cfg_t;

endpackage

// File: src/hilbert_axes_to_transpose.sv
// Hilbert axes-to-transpose converter: one registered cell per bit level from
// COORD_BITS-1 down to 1, then a Gray stage and a correction stage. Throughput
// one word per cycle unless stalled; each stage holds its own valid bit and stalls
// only when full and blocked downstream; ready ripples back combinationally to the input.
// Reset clears all valid bits and loads bits_per_axis = 32, num_axes = 3.
// Depends on hatt_pkg, hatt_cell and hatt_gray.
module hilbert_axes_to_transpose #(
    parameter int MAX_AXES   = 4,
    parameter int COORD_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [hatt_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [hatt_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata from bit 0: coord_0, coord_1, coord_2, coord_3 (32 bits each)
    input  logic [hatt_pkg::FIELD_AXES*hatt_pkg::FIELD_W-1:0] s_axis_tdata,
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata from bit 0: index_0, index_1, index_2, index_3 (32 bits each)
    output logic [hatt_pkg::FIELD_AXES*hatt_pkg::FIELD_W-1:0] m_axis_tdata
);
    import hatt_pkg::*;

    // Lanes actually built: the stream carries at most FIELD_AXES coordinates
    localparam int LANES = (MAX_AXES < FIELD_AXES) ? MAX_AXES : FIELD_AXES;
    // One cell per undo level, bit COORD_BITS-1 down to bit 1
    localparam int NCELL = COORD_BITS - 1;

    logic [BPA_W-1:0]  bits_per_axis_reg;
    logic [BPA_W-1:0]  bits_per_axis_next;
    logic [AXES_W-1:0] num_axes_reg;
    logic [AXES_W-1:0] num_axes_next;
    hatt_cfg_t         eff;

    logic                             stg_valid [NCELL+1];
    logic                             stg_ready [NCELL+1];
    logic [LANES-1:0][COORD_BITS-1:0] stg_data  [NCELL+1];
    logic [LANES-1:0][COORD_BITS-1:0] out_data;

    // Config registers; the user writes them only while the pipe is idle; not enforced
    always_comb
    begin
        bits_per_axis_next = bits_per_axis_reg;
        num_axes_next      = num_axes_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_BITS_PER_AXIS: bits_per_axis_next = cfg_data[BPA_W-1:0];
                REG_NUM_AXES:      num_axes_next      = cfg_data[AXES_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_per_axis_reg <= BPA_W'(32);
            num_axes_reg      <= AXES_W'(3);
        end
        else
        begin
            bits_per_axis_reg <= bits_per_axis_next;
            num_axes_reg      <= num_axes_next;
        end
    end

    // Clamp: zero counts behave as one, large counts saturate
    always_comb
    begin
        eff.eff_bits = bits_per_axis_reg;
        if (bits_per_axis_reg == '0)
        begin
            eff.eff_bits = BPA_W'(1);
        end
        else if (int'(bits_per_axis_reg) > COORD_BITS)
        begin
            eff.eff_bits = BPA_W'(COORD_BITS);
        end
        eff.eff_axes = num_axes_reg;
        if (num_axes_reg == '0)
        begin
            eff.eff_axes = AXES_W'(1);
        end
        else if (int'(num_axes_reg) > LANES)
        begin
            eff.eff_axes = AXES_W'(LANES);
        end
    end

    // Unpack coordinates: drop bits above COORD_BITS, zero the unused axes
    always_comb
    begin
        logic [FIELD_W-1:0] field;
        field = '0;
        for (int i = 0; i < LANES; i++)
        begin
            field = s_axis_tdata[i*FIELD_W +: FIELD_W];
            stg_data[0][i] = (i < int'(eff.eff_axes)) ? field[COORD_BITS-1:0] : '0;
        end
    end

    assign stg_valid[0]  = s_axis_tvalid;
    assign s_axis_tready = stg_ready[0];

    // Row of undo cells, top bit level first
    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        hatt_cell #(
            .LANES      (LANES),
            .COORD_BITS (COORD_BITS),
            .LEVEL      (COORD_BITS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (eff),
            .in_valid  (stg_valid[j]),
            .in_ready  (stg_ready[j]),
            .in_data   (stg_data[j]),
            .out_valid (stg_valid[j+1]),
            .out_ready (stg_ready[j+1]),
            .out_data  (stg_data[j+1])
        );
    end

    // Gray encode and correction; its second register is the output register
    hatt_gray #(
        .LANES      (LANES),
        .COORD_BITS (COORD_BITS)
    ) u_gray (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (eff),
        .in_valid  (stg_valid[NCELL]),
        .in_ready  (stg_ready[NCELL]),
        .in_data   (stg_data[NCELL]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack results; fields past the built lanes stay zero
    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < LANES; i++)
        begin
            m_axis_tdata[i*FIELD_W +: FIELD_W] = FIELD_W'(out_data[i]);
        end
    end

    // A free output leaves every stage able to advance
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    a_axis1_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (eff.eff_axes < AXES_W'(2)) |->
            m_axis_tdata[2*FIELD_W-1:FIELD_W] == '0)
        else $error("unused axis 1 carries data");

    a_axis3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (eff.eff_axes < AXES_W'(4)) |->
            m_axis_tdata[4*FIELD_W-1:3*FIELD_W] == '0)
        else $error("unused axis 3 carries data");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_idx == REG_NUM_AXES) |=>
            num_axes_reg == $past(cfg_data[AXES_W-1:0]))
        else $error("axis count write lost");

endmodule

// File: src/hatt_cell.sv
// One bit-level cell of the inverse undo pass, with its own pipeline register.
// Depends on hatt_pkg for the configuration struct.
module hatt_cell #(
    parameter int LANES      = 4,
    parameter int COORD_BITS = 32,
    parameter int LEVEL      = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hatt_pkg::hatt_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [LANES-1:0][COORD_BITS-1:0] in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [LANES-1:0][COORD_BITS-1:0] out_data
);
    import hatt_pkg::*;

    localparam logic [COORD_BITS-1:0] LOW_MASK = COORD_BITS'((64'd1 << LEVEL) - 64'd1);

    logic                             valid_reg;
    logic                             valid_next;
    logic [LANES-1:0][COORD_BITS-1:0] data_reg;
    logic [LANES-1:0][COORD_BITS-1:0] data_next;
    logic [LANES-1:0][COORD_BITS-1:0] undo;

    // Walk the axes in order; axis 0 is updated along the way
    always_comb
    begin
        logic [COORD_BITS-1:0] t;
        undo = in_data;
        t    = '0;
        if (int'(cfg.eff_bits) > LEVEL)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (i < int'(cfg.eff_axes))
                begin
                    if (undo[i][LEVEL])
                    begin
                        undo[0] = undo[0] ^ LOW_MASK;
                    end
                    else
                    begin
                        t       = (undo[0] ^ undo[i]) & LOW_MASK;
                        undo[0] = undo[0] ^ t;
                        undo[i] = undo[i] ^ t;
                    end
                end
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                data_next = undo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/hatt_gray.sv
// Gray encode across the axes and the correction mask from the last axis.
// Two pipeline registers; depends on hatt_pkg for the configuration struct.
module hatt_gray #(
    parameter int LANES      = 4,
    parameter int COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hatt_pkg::hatt_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [LANES-1:0][COORD_BITS-1:0] in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [LANES-1:0][COORD_BITS-1:0] out_data
);
    import hatt_pkg::*;

    logic                             a_valid_reg;
    logic                             a_valid_next;
    logic [LANES-1:0][COORD_BITS-1:0] a_data_reg;
    logic [LANES-1:0][COORD_BITS-1:0] a_data_next;
    logic                             b_valid_reg;
    logic                             b_valid_next;
    logic [LANES-1:0][COORD_BITS-1:0] b_data_reg;
    logic [LANES-1:0][COORD_BITS-1:0] b_data_next;
    logic                             b_ready;
    logic [LANES-1:0][COORD_BITS-1:0] gray;
    logic [LANES-1:0][COORD_BITS-1:0] fixed;

    // Running XOR over the axes in use
    always_comb
    begin
        gray = in_data;
        for (int i = 1; i < LANES; i++)
        begin
            if (i < int'(cfg.eff_axes))
            begin
                gray[i] = gray[i] ^ gray[i-1];
            end
        end
    end

    // Correction bit j is the parity of last-axis bits above j and below the bit count
    always_comb
    begin
        logic [COORD_BITS-1:0] last;
        logic [COORD_BITS-1:0] sel;
        logic [COORD_BITS-1:0] corr;
        last = '0;
        sel  = '0;
        corr = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (i == int'(cfg.eff_axes) - 1)
            begin
                last = a_data_reg[i];
            end
        end
        for (int j = 0; j < COORD_BITS; j++)
        begin
            for (int k = 0; k < COORD_BITS; k++)
            begin
                sel[k] = (k > j) && (k < int'(cfg.eff_bits));
            end
            corr[j] = ^(last & sel);
        end
        for (int i = 0; i < LANES; i++)
        begin
            fixed[i] = (i < int'(cfg.eff_axes)) ? (a_data_reg[i] ^ corr) : '0;
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_data_next  = a_data_reg;
        b_valid_next = b_valid_reg;
        b_data_next  = b_data_reg;
        if (in_ready)
        begin
            a_valid_next = in_valid;
            if (in_valid)
            begin
                a_data_next = gray;
            end
        end
        if (b_ready)
        begin
            b_valid_next = a_valid_reg;
            if (a_valid_reg)
            begin
                b_data_next = fixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_data_reg <= a_data_next;
        b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule
